// File: sv/mtc_pkg.sv
// mtc_pkg: shared constants, request codes, microcode word and control ROM
// for the multi-terminal text console; no dependencies
`default_nettype none

package mtc_pkg;

  localparam int NUM_SCREENS_DEF = 4;
  localparam int COLUMNS_DEF     = 80;
  localparam int ROWS_DEF        = 25;

  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int SEL_W  = 3;
  localparam int IDX_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int TERM_W = 2;
  localparam int DATA_W = 16;
  localparam int ATTR_W = 8;
  localparam int STEP_W = 5;

  localparam logic [DATA_W-1:0] RESET_CELL = 16'h0F20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
  localparam logic [ATTR_W-1:0] IND_ATTR   = 8'h1F;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LBRK    = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_F       = 8'h46;
  localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
  localparam logic [CHAR_W-1:0] CH_RBRK    = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_FIRST   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST    = 8'h7E;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT, REQ_SWITCH, REQ_CLEAR, REQ_READ
  } req_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_INPUT, C_MORE, C_ROW_OK, C_NOFLAG, C_OUT_BUSY
  } cond_t;

  typedef enum logic [2:0] {
    R_NONE, R_RD_SRC, R_RD_IDX, R_WR_COPY, R_WR_BLANK, R_WR_INIT,
    R_WR_CUR_BLANK, R_WR_CUR_CHAR
  } ram_op_t;

  typedef enum logic [1:0] {P_HOLD, P_BASE, P_ZERO, P_INC} ptr_op_t;

  typedef enum logic [2:0] {
    N_HOLD, N_COPY, N_LINE, N_SCREEN, N_ALL, N_DEC
  } cnt_op_t;

  typedef enum logic [3:0] {
    U_NONE, U_NL, U_CR, U_TAB, U_BS, U_WRAP, U_LAST, U_ADV, U_ZERO
  } cur_op_t;

  typedef enum logic [1:0] {M_NONE, M_SWITCH, M_LATCH, M_EMIT} misc_op_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE     = 5'd0;
  localparam step_t ST_NL       = 5'd1;
  localparam step_t ST_CR       = 5'd2;
  localparam step_t ST_TAB      = 5'd3;
  localparam step_t ST_BS       = 5'd4;
  localparam step_t ST_BS_WR    = 5'd5;
  localparam step_t ST_WRAP     = 5'd6;
  localparam step_t ST_CHK      = 5'd7;
  localparam step_t ST_CP_RD    = 5'd8;
  localparam step_t ST_CP_WR    = 5'd9;
  localparam step_t ST_BL_SET   = 5'd10;
  localparam step_t ST_BL_WR    = 5'd11;
  localparam step_t ST_LAST     = 5'd12;
  localparam step_t ST_PUT      = 5'd13;
  localparam step_t ST_CLR_SET  = 5'd14;
  localparam step_t ST_CLR_WR   = 5'd15;
  localparam step_t ST_EMIT     = 5'd16;
  localparam step_t ST_RD       = 5'd17;
  localparam step_t ST_RD_LATCH = 5'd18;
  localparam step_t ST_SW       = 5'd19;
  localparam step_t ST_INIT0    = 5'd20;
  localparam step_t ST_INIT1    = 5'd21;

  typedef struct packed {
    cond_t    cond;
    step_t    target;
    logic     fin;
    logic     take;
    ram_op_t  ram_op;
    ptr_op_t  ptr_op;
    cnt_op_t  cnt_op;
    cur_op_t  cur_op;
    misc_op_t misc_op;
  } uword_t;

  typedef struct packed {
    logic  in_valid;
    step_t entry;
    logic  more;
    logic  row_ok;
    logic  flag;
    logic  out_busy;
  } dp_status_t;

  function automatic uword_t uw(cond_t c, step_t t, logic f, logic tk, ram_op_t r,
                                ptr_op_t p, cnt_op_t n, cur_op_t u, misc_op_t m);
    uword_t w;
    w = '{cond: c, target: t, fin: f, take: tk, ram_op: r, ptr_op: p,
          cnt_op: n, cur_op: u, misc_op: m};
    return w;
  endfunction

  // control store: one word per step
  function automatic uword_t ucode(step_t s);
    uword_t w;
    unique case (s)
      ST_IDLE:     w = uw(C_INPUT, ST_IDLE, 1'b1, 1'b1, R_NONE, P_HOLD, N_HOLD, U_NONE,
                          M_NONE);
      ST_NL:       w = uw(C_ALWAYS, ST_EMIT, 1'b0, 1'b0, R_NONE, P_HOLD, N_HOLD, U_NL,
                          M_NONE);
      ST_CR:       w = uw(C_ALWAYS, ST_EMIT, 1'b0, 1'b0, R_NONE, P_HOLD, N_HOLD, U_CR,
                          M_NONE);
      ST_TAB:      w = uw(C_ALWAYS, ST_EMIT, 1'b0, 1'b0, R_NONE, P_HOLD, N_HOLD, U_TAB,
                          M_NONE);
      ST_BS:       w = uw(C_NOFLAG, ST_EMIT, 1'b0, 1'b0, R_NONE, P_HOLD, N_HOLD, U_BS,
                          M_NONE);
      ST_BS_WR:    w = uw(C_ALWAYS, ST_EMIT, 1'b0, 1'b0, R_WR_CUR_BLANK, P_HOLD, N_HOLD,
                          U_NONE, M_NONE);
      ST_WRAP:     w = uw(C_NEVER, ST_IDLE, 1'b0, 1'b0, R_NONE, P_HOLD, N_HOLD, U_WRAP,
                          M_NONE);
      ST_CHK:      w = uw(C_ROW_OK, ST_PUT, 1'b0, 1'b0, R_NONE, P_BASE, N_COPY, U_NONE,
                          M_NONE);
      ST_CP_RD:    w = uw(C_NEVER, ST_IDLE, 1'b0, 1'b0, R_RD_SRC, P_HOLD, N_HOLD, U_NONE,
                          M_NONE);
      ST_CP_WR:    w = uw(C_MORE, ST_CP_RD, 1'b0, 1'b0, R_WR_COPY, P_INC, N_DEC, U_NONE,
                          M_NONE);
      ST_BL_SET:   w = uw(C_NEVER, ST_IDLE, 1'b0, 1'b0, R_NONE, P_HOLD, N_LINE, U_NONE,
                          M_NONE);
      ST_BL_WR:    w = uw(C_MORE, ST_BL_WR, 1'b0, 1'b0, R_WR_BLANK, P_INC, N_DEC, U_NONE,
                          M_NONE);
      ST_LAST:     w = uw(C_NEVER, ST_IDLE, 1'b0, 1'b0, R_NONE, P_HOLD, N_HOLD, U_LAST,
                          M_NONE);
      ST_PUT:      w = uw(C_ALWAYS, ST_EMIT, 1'b0, 1'b0, R_WR_CUR_CHAR, P_HOLD, N_HOLD,
                          U_ADV, M_NONE);
      ST_CLR_SET:  w = uw(C_NEVER, ST_IDLE, 1'b0, 1'b0, R_NONE, P_BASE, N_SCREEN, U_ZERO,
                          M_NONE);
      ST_CLR_WR:   w = uw(C_MORE, ST_CLR_WR, 1'b0, 1'b0, R_WR_BLANK, P_INC, N_DEC, U_NONE,
                          M_NONE);
      ST_EMIT:     w = uw(C_OUT_BUSY, ST_EMIT, 1'b1, 1'b0, R_NONE, P_HOLD, N_HOLD, U_NONE,
                          M_EMIT);
      ST_RD:       w = uw(C_NEVER, ST_IDLE, 1'b0, 1'b0, R_RD_IDX, P_HOLD, N_HOLD, U_NONE,
                          M_NONE);
      ST_RD_LATCH: w = uw(C_ALWAYS, ST_EMIT, 1'b0, 1'b0, R_NONE, P_HOLD, N_HOLD, U_NONE,
                          M_LATCH);
      ST_SW:       w = uw(C_ALWAYS, ST_EMIT, 1'b0, 1'b0, R_NONE, P_HOLD, N_HOLD, U_NONE,
                          M_SWITCH);
      ST_INIT0:    w = uw(C_NEVER, ST_IDLE, 1'b0, 1'b0, R_NONE, P_ZERO, N_ALL, U_NONE,
                          M_NONE);
      ST_INIT1:    w = uw(C_MORE, ST_INIT1, 1'b1, 1'b0, R_WR_INIT, P_INC, N_DEC, U_NONE,
                          M_NONE);
      default:     w = uw(C_NEVER, ST_IDLE, 1'b1, 1'b0, R_NONE, P_HOLD, N_HOLD, U_NONE,
                          M_NONE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: sv/mtc_if.sv
// mtc_if: request, result and attribute-write channel interfaces
// depends on mtc_pkg for field widths
`default_nettype none

interface mtc_in_if;
  import mtc_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;
  logic [SEL_W-1:0]  term_select;
  logic [IDX_W-1:0]  cell_index;
  modport source (output valid, req_type, char_code, term_select, cell_index,
                  input ready);
  modport sink (input valid, req_type, char_code, term_select, cell_index,
                output ready);
endinterface

interface mtc_out_if;
  import mtc_pkg::*;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [TERM_W-1:0] current_term;
  logic [DATA_W-1:0] read_data;
  logic              request_ignored;
  modport source (output valid, cursor_col, cursor_row, current_term, read_data,
                  request_ignored, input ready);
  modport sink (input valid, cursor_col, cursor_row, current_term, read_data,
                request_ignored, output ready);
endinterface

interface mtc_cfg_if;
  import mtc_pkg::*;
  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: sv/multi_terminal_text_console.sv
// multi_terminal_text_console: top level, microcoded sequencer driving the
// console datapath and cell RAM; depends on mtc_pkg, mtc_if, mtc_ram, mtc_seq, mtc_dp
//
//   channel   dir  handshake      word
//   in_chan   in   valid/ready    req_type, char_code, term_select, cell_index
//   out_chan  out  valid/ready    cursor_col, cursor_row, current_term, read_data,
//                                 request_ignored
//   cfg_chan  in   valid/ready    data (text attribute), always ready
//
// in_chan.ready is high in the idle step only; an ignored request goes straight to
// the emit step, other items pass their own steps first: ST_NL, ST_CR, ST_TAB or
// ST_SW; ST_BS, then ST_BS_WR if it erases; ST_RD and ST_RD_LATCH for a read;
// ST_WRAP, ST_CHK and ST_PUT for a printable. a printable that moves past the last
// row first scrolls, each cell copy a read step then a write step, and blanks the
// last row; a clear blanks the ROWS*COLUMNS cells of the shown screen.
// after reset a clearing pass writes all NUM_SCREENS*ROWS*COLUMNS cells before
// the first item is taken.
// a stalled result holds the sequencer in its emit step; the result register
// lets the next item be accepted while the previous word waits.
`default_nettype none

module multi_terminal_text_console #(
  parameter int NUM_SCREENS = mtc_pkg::NUM_SCREENS_DEF,
  parameter int COLUMNS     = mtc_pkg::COLUMNS_DEF,
  parameter int ROWS        = mtc_pkg::ROWS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mtc_in_if.sink    in_chan,
  mtc_out_if.source out_chan,
  mtc_cfg_if.sink   cfg_chan
);
  import mtc_pkg::*;

  localparam int MEM_DEPTH = NUM_SCREENS * ROWS * COLUMNS;
  localparam int AW        = $clog2(MEM_DEPTH);

  uword_t            ctl;
  dp_status_t        st;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  mtc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctl   (ctl)
  );

  mtc_dp #(
    .NUM_SCREENS (NUM_SCREENS),
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .AW          (AW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .st        (st),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_chan  (cfg_chan),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  mtc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// File: sv/mtc_ram.sv
// mtc_ram: generic single-write, single-read RAM with registered read
// no dependencies
`default_nettype none

module mtc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/mtc_seq.sv
// mtc_seq: step counter and control store walk with conditional jumps
// depends on mtc_pkg
`default_nettype none

module mtc_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mtc_pkg::dp_status_t st,
  output mtc_pkg::uword_t          ctl
);
  import mtc_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  jump;

  always_comb begin
    ctl = ucode(step_r);
    unique case (ctl.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_INPUT:    jump = st.in_valid;
      C_MORE:     jump = st.more;
      C_ROW_OK:   jump = st.row_ok;
      C_NOFLAG:   jump = !st.flag;
      C_OUT_BUSY: jump = st.out_busy;
      default:    jump = 1'b0;
    endcase
    if (jump) begin
      step_nxt = (ctl.cond == C_INPUT) ? st.entry : ctl.target;
    end else if (ctl.fin) begin
      step_nxt = ST_IDLE;
    end else begin
      step_nxt = step_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_INIT0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/mtc_dp.sv
// mtc_dp: console datapath - cursors, shown screen, address pointer and
// count, request decode and result register; depends on mtc_pkg, mtc_if
`default_nettype none

module mtc_dp #(
  parameter int NUM_SCREENS = mtc_pkg::NUM_SCREENS_DEF,
  parameter int COLUMNS     = mtc_pkg::COLUMNS_DEF,
  parameter int ROWS        = mtc_pkg::ROWS_DEF,
  parameter int AW          = 13
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mtc_pkg::uword_t         ctl,
  output mtc_pkg::dp_status_t          st,
  mtc_in_if.sink                       in_chan,
  mtc_out_if.source                    out_chan,
  mtc_cfg_if.sink                      cfg_chan,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [mtc_pkg::DATA_W-1:0]   ram_wdata,
  output logic                         ram_re,
  output logic [AW-1:0]                ram_raddr,
  input  wire logic [mtc_pkg::DATA_W-1:0] ram_rdata
);
  import mtc_pkg::*;

  localparam int SC        = ROWS * COLUMNS;
  localparam int MEM_DEPTH = NUM_SCREENS * SC;
  localparam int CNT_W     = $clog2(MEM_DEPTH + 1);
  localparam int SW        = (NUM_SCREENS > 1) ? $clog2(NUM_SCREENS) : 1;

  logic [ATTR_W-1:0] attr_r;
  logic [SW-1:0]     shown_r;
  logic [COL_W-1:0]  col_r [NUM_SCREENS];
  logic [ROW_W-1:0]  row_r [NUM_SCREENS];
  logic [CHAR_W-1:0] ch_r;
  logic [IDX_W-1:0]  idx_r;
  logic [SEL_W-1:0]  sel_r;
  logic              ign_r;
  logic              flag_r;
  logic [DATA_W-1:0] data_r;
  logic [AW-1:0]     ptr_r;
  logic [AW-1:0]     ptr_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              out_valid_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [TERM_W-1:0] out_term_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_ign_r;

  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  row_nxt;
  logic [ROW_W-1:0]  row_inc;
  logic [COL_W-1:0]  tab_sum;
  logic [COL_W-1:0]  tab_al;
  logic [COL_W-1:0]  tab_col;
  logic [AW-1:0]     base;
  logic [AW-1:0]     cur_addr;
  logic [DATA_W-1:0] blank;
  logic [IDX_W-1:0]  ind_off;
  logic [DATA_W-1:0] rd_view;
  logic              accept;
  logic              out_busy;
  logic              emit;
  step_t             entry;
  logic              ign_d;
  logic              flag_d;

  assign cur_col  = col_r[shown_r];
  assign cur_row  = row_r[shown_r];
  assign base     = AW'(shown_r) * AW'(SC);
  assign cur_addr = base + AW'(cur_row) * AW'(COLUMNS) + AW'(cur_col);
  assign blank    = {attr_r, BLANK_CHAR};
  assign row_inc  = (cur_row < ROW_W'(ROWS)) ? cur_row + 5'd1 : cur_row;
  assign tab_sum  = cur_col + 7'd8;
  assign tab_al   = {tab_sum[COL_W-1:3], 3'b000};
  assign tab_col  = (tab_al > COL_W'(COLUMNS)) ? COL_W'(COLUMNS) : tab_al;

  assign accept   = ctl.take && in_chan.valid;
  assign out_busy = out_valid_r && !out_chan.ready;
  assign emit     = (ctl.misc_op == M_EMIT) && !out_busy;

  assign in_chan.ready  = ctl.take;
  assign cfg_chan.ready = 1'b1;

  assign st.in_valid = in_chan.valid;
  assign st.entry    = entry;
  assign st.more     = cnt_r != CNT_W'(1);
  assign st.row_ok   = cur_row < ROW_W'(ROWS);
  assign st.flag     = flag_r;
  assign st.out_busy = out_busy;

  assign out_chan.valid           = out_valid_r;
  assign out_chan.cursor_col      = out_col_r;
  assign out_chan.cursor_row      = out_row_r;
  assign out_chan.current_term    = out_term_r;
  assign out_chan.read_data       = out_data_r;
  assign out_chan.request_ignored = out_ign_r;

  // request decode
  always_comb begin
    entry  = ST_EMIT;
    ign_d  = 1'b0;
    flag_d = 1'b0;
    unique case (in_chan.req_type)
      REQ_PUT: begin
        if (in_chan.char_code == CH_NL) begin
          entry = ST_NL;
        end else if (in_chan.char_code == CH_CR) begin
          entry = ST_CR;
        end else if (in_chan.char_code == CH_TAB) begin
          entry = ST_TAB;
        end else if (in_chan.char_code == CH_BS) begin
          entry  = ST_BS;
          flag_d = (cur_col != '0) && (cur_row < ROW_W'(ROWS));
        end else if (in_chan.char_code >= CH_FIRST && in_chan.char_code <= CH_LAST) begin
          entry = ST_WRAP;
        end else begin
          ign_d = 1'b1;
        end
      end
      REQ_SWITCH: begin
        if (in_chan.term_select >= SEL_W'(NUM_SCREENS) ||
            in_chan.term_select == SEL_W'(shown_r)) begin
          ign_d = 1'b1;
        end else begin
          entry = ST_SW;
        end
      end
      REQ_CLEAR: begin
        entry = ST_CLR_SET;
      end
      REQ_READ: begin
        if (in_chan.cell_index >= IDX_W'(SC)) begin
          ign_d = 1'b1;
        end else begin
          entry = ST_RD;
        end
      end
      default: begin
        ign_d = 1'b1;
      end
    endcase
  end

  // cursor update
  always_comb begin
    col_nxt = cur_col;
    row_nxt = cur_row;
    case (ctl.cur_op)
      U_NL: begin
        col_nxt = '0;
        row_nxt = row_inc;
      end
      U_CR:  col_nxt = '0;
      U_TAB: col_nxt = tab_col;
      U_BS: begin
        if (cur_col != '0) begin
          col_nxt = cur_col - 7'd1;
        end
      end
      U_WRAP: begin
        if (cur_col >= COL_W'(COLUMNS)) begin
          col_nxt = '0;
          row_nxt = row_inc;
        end
      end
      U_LAST: row_nxt = ROW_W'(ROWS - 1);
      U_ADV:  col_nxt = cur_col + 7'd1;
      U_ZERO: begin
        col_nxt = '0;
        row_nxt = '0;
      end
      default: begin
        col_nxt = cur_col;
      end
    endcase
  end

  // pointer and count
  always_comb begin
    case (ctl.ptr_op)
      P_BASE:  ptr_nxt = base;
      P_ZERO:  ptr_nxt = '0;
      P_INC:   ptr_nxt = ptr_r + AW'(1);
      default: ptr_nxt = ptr_r;
    endcase
    case (ctl.cnt_op)
      N_COPY:   cnt_nxt = CNT_W'((ROWS - 1) * COLUMNS);
      N_LINE:   cnt_nxt = CNT_W'(COLUMNS);
      N_SCREEN: cnt_nxt = CNT_W'(SC);
      N_ALL:    cnt_nxt = CNT_W'(MEM_DEPTH);
      N_DEC:    cnt_nxt = cnt_r - CNT_W'(1);
      default:  cnt_nxt = cnt_r;
    endcase
  end

  // cell memory port
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ptr_r;
    ram_raddr = ptr_r + AW'(COLUMNS);
    ram_wdata = blank;
    case (ctl.ram_op)
      R_RD_SRC: ram_re = 1'b1;
      R_RD_IDX: begin
        ram_re    = 1'b1;
        ram_raddr = base + AW'(idx_r);
      end
      R_WR_COPY: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      R_WR_BLANK: ram_we = 1'b1;
      R_WR_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
      end
      R_WR_CUR_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
      end
      R_WR_CUR_CHAR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = {attr_r, ch_r};
      end
      default: ram_we = 1'b0;
    endcase
  end

  // screen indicator overlay on row 0
  assign ind_off = idx_r - IDX_W'(COLUMNS - 4);
  always_comb begin
    rd_view = ram_rdata;
    if (idx_r >= IDX_W'(COLUMNS - 4) && idx_r < IDX_W'(COLUMNS)) begin
      case (ind_off[1:0])
        2'd0:    rd_view = {IND_ATTR, CH_LBRK};
        2'd1:    rd_view = {IND_ATTR, CH_F};
        2'd2:    rd_view = {IND_ATTR, CH_ONE + CHAR_W'(shown_r)};
        default: rd_view = {IND_ATTR, CH_RBRK};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= RESET_ATTR;
      shown_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SCREENS; i++) begin
        col_r[i] <= '0;
        row_r[i] <= '0;
      end
    end else begin
      if (cfg_chan.valid) begin
        attr_r <= cfg_chan.data;
      end
      if (ctl.misc_op == M_SWITCH) begin
        shown_r <= sel_r[SW-1:0];
      end
      col_r[shown_r] <= col_nxt;
      row_r[shown_r] <= row_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    cnt_r <= cnt_nxt;
    if (accept) begin
      ch_r   <= in_chan.char_code;
      idx_r  <= in_chan.cell_index;
      sel_r  <= in_chan.term_select;
      ign_r  <= ign_d;
      flag_r <= flag_d;
      data_r <= '0;
    end else if (ctl.misc_op == M_LATCH) begin
      data_r <= rd_view;
    end
    if (emit) begin
      out_col_r  <= cur_col;
      out_row_r  <= cur_row;
      out_term_r <= TERM_W'(shown_r);
      out_data_r <= data_r;
      out_ign_r  <= ign_r;
    end
  end

endmodule

`default_nettype wire

// File: sv/mtc_checker.sv
// mtc_checker: port-level assertions for the console, bound to the top level
// depends on mtc_pkg, multi_terminal_text_console
`default_nettype none

module mtc_checker #(
  parameter int NUM_SCREENS = mtc_pkg::NUM_SCREENS_DEF,
  parameter int COLUMNS     = mtc_pkg::COLUMNS_DEF,
  parameter int ROWS        = mtc_pkg::ROWS_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [mtc_pkg::COL_W-1:0]    out_cursor_col,
  input wire logic [mtc_pkg::ROW_W-1:0]    out_cursor_row,
  input wire logic [mtc_pkg::TERM_W-1:0]   out_current_term,
  input wire logic [mtc_pkg::DATA_W-1:0]   out_read_data,
  input wire logic                         out_request_ignored
);
  import mtc_pkg::*;

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
    $stable(out_cursor_col))
    else $error("stalled result changed");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_col <= COLUMNS && out_cursor_row <= ROWS &&
    out_current_term < NUM_SCREENS)
    else $error("cursor or screen out of range");

  a_ignored_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_request_ignored |-> out_read_data == '0)
    else $error("ignored request carries read data");

endmodule

bind multi_terminal_text_console mtc_checker #(
  .NUM_SCREENS (NUM_SCREENS),
  .COLUMNS     (COLUMNS),
  .ROWS        (ROWS)
) u_mtc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_chan.valid),
  .in_ready            (in_chan.ready),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_cursor_col      (out_chan.cursor_col),
  .out_cursor_row      (out_chan.cursor_row),
  .out_current_term    (out_chan.current_term),
  .out_read_data       (out_chan.read_data),
  .out_request_ignored (out_chan.request_ignored)
);

`default_nettype wire
